/* hw/rtl/gisc_pkg.sv */
package gisc_pkg;

  // grid geometry
  localparam int MAX_SIDE = 128;
  localparam int ROW_W    = $clog2(MAX_SIDE);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int SWEEP_W  = $clog2(MAX_SIDE + 2);
  localparam int IDX_W    = $clog2(MAX_SIDE * MAX_SIDE + 1);

  // field widths
  localparam int CFG_W     = 8;
  localparam int GEN_W     = CFG_W;
  localparam int CELL_W    = 2;
  localparam int COUNT_W   = 15;
  localparam int COUNT_MAX = 2 ** COUNT_W - 1;

  // count pass works on slices of a row
  localparam int CHUNK_W     = 8;
  localparam int N_CHUNKS    = (MAX_SIDE + CHUNK_W - 1) / CHUNK_W;
  localparam int CHUNK_IDX_W = (N_CHUNKS > 1) ? $clog2(N_CHUNKS) : 1;
  localparam int PAD_SIDE    = N_CHUNKS * CHUNK_W;
  localparam int CHUNK_SUM_W = $clog2(CHUNK_W + 1);

  // position remap after a side change: start, one step per quotient bit, commit
  localparam int DIV_CNT_W = $clog2(IDX_W + 2);

  // register port
  localparam int APB_DW    = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_GRID_SIDE  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_DAY_NUMBER = REG_IDX_W'(1);

  // cell codes
  localparam logic [CELL_W-1:0] CELL_EMPTY    = 2'd0;
  localparam logic [CELL_W-1:0] CELL_HEALTHY  = 2'd1;
  localparam logic [CELL_W-1:0] CELL_INFECTED = 2'd2;

  typedef logic [MAX_SIDE-1:0][CELL_W-1:0] row_t;

  // controller to datapath
  typedef struct packed {
    logic                   load_we;
    logic                   load_clear;
    logic                   div_start;
    logic                   div_step;
    logic                   div_commit;
    logic                   rd_en;
    logic [ROW_W-1:0]       rd_row;
    logic                   shift;
    logic                   prev_clear;
    logic                   sweep_wr;
    logic [ROW_W-1:0]       wr_row;
    logic                   last_row;
    logic                   cnt_clear;
    logic                   cnt_acc;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic                   out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [SIDE_W-1:0]      side;
    logic [CHUNK_IDX_W-1:0] last_chunk;
    logic                   out_free;
  } status_t;

  // side in use: zero reads as one, large values clip to the maximum
  function automatic logic [SIDE_W-1:0] side_clip(input logic [CFG_W-1:0] cfg);
    if (cfg == '0) begin
      side_clip = SIDE_W'(1);
    end else if (int'(cfg) > MAX_SIDE) begin
      side_clip = SIDE_W'(MAX_SIDE);
    end else begin
      side_clip = SIDE_W'(cfg);
    end
  endfunction

endpackage

/* hw/rtl/gisc_in_if.sv */
interface gisc_in_if;
  logic                         valid;
  logic                         ready;
  logic [gisc_pkg::CELL_W-1:0]  cell_code;
  logic                         last_cell;

  modport source (output valid, output cell_code, output last_cell, input ready);
  modport sink (input valid, input cell_code, input last_cell, output ready);
endinterface

/* hw/rtl/gisc_out_if.sv */
interface gisc_out_if;
  logic                          valid;
  logic                          ready;
  logic [gisc_pkg::COUNT_W-1:0]  infected_count;

  modport source (output valid, output infected_count, input ready);
  modport sink (input valid, input infected_count, output ready);
endinterface

/* hw/rtl/gisc_ctrl.sv */
module gisc_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_last_i,
  input  logic [gisc_pkg::CFG_W-1:0]     day_number_i,
  input  logic                           side_wr_i,
  input  gisc_pkg::status_t              status_i,
  output logic                           in_ready_o,
  output gisc_pkg::cmd_t                 cmd_o
);
  import gisc_pkg::*;

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_DIV     = 3'd1;
  localparam logic [2:0] S_GEN     = 3'd2;
  localparam logic [2:0] S_CNT_RD  = 3'd3;
  localparam logic [2:0] S_CNT_ACC = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [DIV_CNT_W-1:0]   div_cnt_q, div_cnt_d;
  logic [SWEEP_W-1:0]     t_q, t_d;
  logic [GEN_W-1:0]       gen_q, gen_d;
  logic [ROW_W-1:0]       row_q, row_d;
  logic [CHUNK_IDX_W-1:0] chunk_q, chunk_d;

  logic [GEN_W-1:0]       gens;
  logic [ROW_W-1:0]       side_m1;
  logic [SWEEP_W-1:0]     sweep_end;
  logic                   accept;

  // generations to run for the requested day
  assign gens      = (day_number_i > CFG_W'(1)) ? GEN_W'(day_number_i - CFG_W'(1)) : '0;
  assign side_m1   = ROW_W'(status_i.side - SIDE_W'(1));
  assign sweep_end = SWEEP_W'(status_i.side) + SWEEP_W'(1);
  assign accept    = (state_q == S_LOAD) && in_valid_i;
  assign in_ready_o = (state_q == S_LOAD);

  // sequencing
  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    t_d       = t_q;
    gen_d     = gen_q;
    row_d     = row_q;
    chunk_d   = chunk_q;
    cmd_o     = '0;

    case (state_q)
      S_LOAD: begin
        cmd_o.load_we = accept;
        if (accept && in_last_i) begin
          cmd_o.load_clear = 1'b1;
          t_d   = '0;
          gen_d = '0;
          row_d = '0;
          if (gens == '0) begin
            state_d = S_CNT_RD;
          end else begin
            state_d = S_GEN;
          end
        end else if (side_wr_i) begin
          div_cnt_d = '0;
          state_d   = S_DIV;
        end
      end

      // remap load position to the new side
      S_DIV: begin
        if (side_wr_i) begin
          div_cnt_d = '0;
        end else begin
          cmd_o.div_start  = (div_cnt_q == '0);
          cmd_o.div_step   = (div_cnt_q != '0) && (div_cnt_q <= DIV_CNT_W'(IDX_W));
          cmd_o.div_commit = (div_cnt_q == DIV_CNT_W'(IDX_W + 1));
          div_cnt_d        = div_cnt_q + DIV_CNT_W'(1);
          if (cmd_o.div_commit) begin
            state_d = S_LOAD;
          end
        end
      end

      // one generation: read row t, rewrite row t-2 in place
      S_GEN: begin
        cmd_o.rd_en      = (t_q < SWEEP_W'(status_i.side));
        cmd_o.rd_row     = t_q[ROW_W-1:0];
        cmd_o.shift      = 1'b1;
        cmd_o.prev_clear = (t_q <= SWEEP_W'(1));
        cmd_o.sweep_wr   = (t_q >= SWEEP_W'(2));
        cmd_o.wr_row     = ROW_W'(t_q - SWEEP_W'(2));
        cmd_o.last_row   = (t_q == sweep_end);
        if (t_q == sweep_end) begin
          t_d = '0;
          if (GEN_W'(gen_q + GEN_W'(1)) == gens) begin
            row_d   = '0;
            state_d = S_CNT_RD;
          end else begin
            gen_d = gen_q + GEN_W'(1);
          end
        end else begin
          t_d = t_q + SWEEP_W'(1);
        end
      end

      S_CNT_RD: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_row    = row_q;
        cmd_o.cnt_clear = (row_q == '0);
        chunk_d         = '0;
        state_d         = S_CNT_ACC;
      end

      S_CNT_ACC: begin
        cmd_o.cnt_acc = 1'b1;
        cmd_o.chunk   = chunk_q;
        if (chunk_q == status_i.last_chunk) begin
          if (row_q == side_m1) begin
            state_d = S_DONE;
          end else begin
            row_d   = row_q + ROW_W'(1);
            state_d = S_CNT_RD;
          end
        end else begin
          chunk_d = chunk_q + CHUNK_IDX_W'(1);
        end
      end

      // wait for the output register
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      div_cnt_q <= '0;
      t_q       <= '0;
      gen_q     <= '0;
      row_q     <= '0;
      chunk_q   <= '0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      t_q       <= t_d;
      gen_q     <= gen_d;
      row_q     <= row_d;
      chunk_q   <= chunk_d;
    end
  end

`ifndef SYNTHESIS
  // the closing cell always starts the computation
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && in_valid_i && in_last_i) |=>
      (state_q == S_GEN || state_q == S_CNT_RD))
    else $error("last cell did not start the computation");

  // loading, sweeping and remapping never overlap
  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_we, cmd_o.rd_en, cmd_o.div_step}))
    else $error("overlapping datapath phases");
`endif

endmodule

/* hw/rtl/gisc_dp.sv */
module gisc_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [gisc_pkg::CFG_W-1:0]     grid_side_i,
  input  logic [gisc_pkg::CELL_W-1:0]    cell_code_i,
  input  gisc_pkg::cmd_t                 cmd_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [gisc_pkg::COUNT_W-1:0]   infected_count_o,
  output gisc_pkg::status_t              status_o
);
  import gisc_pkg::*;

  logic [SIDE_W-1:0]     side;
  logic [2*SIDE_W-1:0]   side_sq;
  logic [MAX_SIDE-1:0]   col_in;

  // load position
  logic [IDX_W-1:0]      load_idx_q;
  logic [ROW_W-1:0]      load_row_q;
  logic [ROW_W-1:0]      load_col_q;
  logic [IDX_W-1:0]      cells_q;
  logic                  store;
  logic [CELL_W-1:0]     cell_clean;

  // remap divider
  logic [IDX_W-1:0]      div_quo_q;
  logic [SIDE_W-1:0]     div_rem_q;
  logic [SIDE_W:0]       div_sh;
  logic                  div_ge;
  logic [SIDE_W:0]       div_diff;

  // grid memory
  row_t                  mem_q [MAX_SIDE];
  row_t                  rdata_q;
  logic                  mem_we;
  logic [ROW_W-1:0]      mem_waddr;
  row_t                  mem_wdata;
  logic [MAX_SIDE-1:0]   mem_mask;

  // generation window
  row_t                  prev_q;
  row_t                  cur_q;
  row_t                  below;
  row_t                  new_row;
  logic [MAX_SIDE-1:0]   up_inf, dn_inf, cur_inf, left_inf, right_inf, hit;

  // count
  logic [MAX_SIDE-1:0]   rd_inf;
  logic [PAD_SIDE-1:0]   rd_inf_pad;
  logic [CHUNK_W-1:0]    chunk_bits;
  logic [CHUNK_SUM_W-1:0] chunk_sum;
  logic [COUNT_W:0]      count_sum;
  logic [COUNT_W-1:0]    count_q;

  // output register
  logic                  out_valid_q;
  logic [COUNT_W-1:0]    out_count_q;

  assign side    = side_clip(grid_side_i);
  assign side_sq = side * side;

  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      col_in[c] = (c < int'(side));
    end
  end

  // cell placement during loading
  assign store      = cmd_i.load_we && (load_idx_q < cells_q);
  assign cell_clean = (cell_code_i inside {CELL_HEALTHY, CELL_INFECTED}) ? cell_code_i
                                                                         : CELL_EMPTY;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
      load_row_q <= '0;
      load_col_q <= '0;
      cells_q    <= IDX_W'(1);
    end else begin
      if (cmd_i.load_clear) begin
        load_idx_q <= '0;
        load_row_q <= '0;
        load_col_q <= '0;
      end else if (store) begin
        load_idx_q <= load_idx_q + IDX_W'(1);
        if (SIDE_W'(load_col_q) == side - SIDE_W'(1)) begin
          load_col_q <= '0;
          load_row_q <= load_row_q + ROW_W'(1);
        end else begin
          load_col_q <= load_col_q + ROW_W'(1);
        end
      end else if (cmd_i.div_commit) begin
        load_row_q <= ROW_W'(div_quo_q);
        load_col_q <= ROW_W'(div_rem_q);
      end
      if (cmd_i.div_start) begin
        cells_q <= IDX_W'(side_sq);
      end
    end
  end

  // restoring divider, one quotient bit per step
  assign div_sh   = {div_rem_q, div_quo_q[IDX_W-1]};
  assign div_ge   = (div_sh >= {1'b0, side});
  assign div_diff = div_sh - {1'b0, side};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_quo_q <= load_idx_q;
      div_rem_q <= '0;
    end else if (cmd_i.div_step) begin
      div_quo_q <= {div_quo_q[IDX_W-2:0], div_ge};
      div_rem_q <= div_ge ? SIDE_W'(div_diff) : SIDE_W'(div_sh);
    end
  end

  // next state of the row in the middle of the window
  assign below = cmd_i.last_row ? '0 : rdata_q;

  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      up_inf[c]  = (prev_q[c] == CELL_INFECTED);
      dn_inf[c]  = (below[c] == CELL_INFECTED);
      cur_inf[c] = (cur_q[c] == CELL_INFECTED);
    end
    left_inf  = cur_inf << 1;
    right_inf = (cur_inf & col_in) >> 1;
    hit       = up_inf | dn_inf | left_inf | right_inf;
    for (int c = 0; c < MAX_SIDE; c++) begin
      new_row[c] = (col_in[c] && cur_q[c] == CELL_HEALTHY && hit[c]) ? CELL_INFECTED
                                                                      : cur_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      cur_q  <= rdata_q;
      prev_q <= cmd_i.prev_clear ? '0 : cur_q;
    end
  end

  // memory write port: one cell while loading, a whole row while sweeping
  assign mem_we    = store || cmd_i.sweep_wr;
  assign mem_waddr = store ? load_row_q : cmd_i.wr_row;
  assign mem_wdata = store ? {MAX_SIDE{cell_clean}} : new_row;
  assign mem_mask  = store ? (MAX_SIDE'(1) << load_col_q) : '1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      for (int i = 0; i < MAX_SIDE; i++) begin
        if (mem_mask[i]) begin
          mem_q[mem_waddr][i] <= mem_wdata[i];
        end
      end
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_row];
    end
  end

  // infected count, one slice of the row per cycle
  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      rd_inf[c] = (rdata_q[c] == CELL_INFECTED);
    end
  end

  assign rd_inf_pad = PAD_SIDE'(rd_inf & col_in);
  assign chunk_bits = rd_inf_pad[cmd_i.chunk * CHUNK_W +: CHUNK_W];

  always_comb begin
    chunk_sum = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      chunk_sum = chunk_sum + CHUNK_SUM_W'(chunk_bits[j]);
    end
  end

  assign count_sum = {1'b0, count_q} + (COUNT_W + 1)'(chunk_sum);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_clear) begin
      count_q <= '0;
    end else if (cmd_i.cnt_acc) begin
      count_q <= (count_sum > (COUNT_W + 1)'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                         : COUNT_W'(count_sum);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_count_q <= count_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign infected_count_o = out_count_q;

  assign status_o.side       = side;
  assign status_o.last_chunk = CHUNK_IDX_W'((side - SIDE_W'(1)) / CHUNK_W);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  // a remapped position of a cell still to come lies inside the grid
  a_remap_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_commit |=> (load_idx_q >= cells_q || SIDE_W'(load_col_q) < $past(side)))
    else $error("remapped column outside the grid");

  // the single write port is never claimed twice
  a_wr_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(store && cmd_i.sweep_wr))
    else $error("load and sweep write in the same cycle");
`endif

endmodule

/* hw/rtl/grid_infection_spread_count.sv */
// Infection spread counter over a square grid.
// Set grid_side (register 0, address 0x0) and day_number (register 1,
// address 0x4) through the register port while no grid is in flight.
// Cells stream in on in_if in row-major order, one transaction per cycle while
// ready is high, code 0 empty, 1 healthy, 2 infected; last_cell closes the grid.
// After the closing cell the block stops taking cells and runs day_number - 1
// generations (none for day_number of 0 or 1): each generation is one
// pass over the row memory with one row read and one row written per cycle,
// and the count pass adds 8 cells per cycle. One result transaction then
// carries the infected count on out_if.
// A write to grid_side while loading remaps the load position to the new side,
// during which no cell is taken.
// The result sits in an output register; loading of the next grid goes on
// while the receiver stalls, and a second result waits until the first one
// is taken. Reset sets grid_side and day_number to 1 and the load position
// to the first cell; the grid memory is not cleared.
module grid_infection_spread_count (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gisc_in_if.sink                           in_if,
  gisc_out_if.source                        out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gisc_pkg::PADDR_W-1:0]      paddr,
  input  logic [gisc_pkg::APB_DW-1:0]       pwdata,
  output logic [gisc_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import gisc_pkg::*;

  logic [CFG_W-1:0]     grid_side_q;
  logic [CFG_W-1:0]     day_number_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic                 side_wr;
  cmd_t                 cmd;
  status_t              status;
  logic                 in_ready;

  // register decode
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign side_wr = wr_en && (reg_idx == REG_GRID_SIDE);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q  <= CFG_W'(1);
      day_number_q <= CFG_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRID_SIDE:  grid_side_q  <= pwdata[CFG_W-1:0];
        REG_DAY_NUMBER: day_number_q <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_GRID_SIDE:  prdata = APB_DW'(grid_side_q);
      REG_DAY_NUMBER: prdata = APB_DW'(day_number_q);
      default:        prdata = '0;
    endcase
  end

  gisc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_last_i    (in_if.last_cell),
    .day_number_i (day_number_q),
    .side_wr_i    (side_wr),
    .status_i     (status),
    .in_ready_o   (in_ready),
    .cmd_o        (cmd)
  );

  gisc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .grid_side_i      (grid_side_q),
    .cell_code_i      (in_if.cell_code),
    .cmd_i            (cmd),
    .out_ready_i      (out_if.ready),
    .out_valid_o      (out_if.valid),
    .infected_count_o (out_if.infected_count),
    .status_o         (status)
  );

  assign in_if.ready = in_ready;

endmodule
